>>> hdl/ising3d_pkg.sv
// Shared types, constants and helpers for the 3D Ising local energy unit.
// No dependencies; imported by the controller, datapath and top module of the block.
`timescale 1ns / 1ps

package ising3d_pkg;

    // Field widths of the stream and configuration payloads
    localparam int SITE_W       = 12;
    localparam int COUPLING_W   = 16;
    localparam int ENERGY_W     = 19;
    localparam int SUM_W        = 4;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;

    localparam int LATTICE_SIDE_DEF = 16;

    // Reciprocal precision of the divide-by-side unit
    localparam int DIV_SHIFT = 24;

    localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;

    // Item kinds carried on tuser
    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_EVAL  = 1'b1;

    // Neighbor read pairs, issued in this order
    localparam logic [1:0] RD_SELF_ZM = 2'd0;
    localparam logic [1:0] RD_ZP_YM   = 2'd1;
    localparam logic [1:0] RD_YP_XM   = 2'd2;
    localparam logic [1:0] RD_XP      = 2'd3;

    typedef enum logic [13:0] {
        ST_CLEAR    = 14'h0001,
        ST_IDLE     = 14'h0002,
        ST_WRITE    = 14'h0004,
        ST_DIV_MUL1 = 14'h0008,
        ST_DIV_FIX1 = 14'h0010,
        ST_DIV_MUL2 = 14'h0020,
        ST_DIV_FIX2 = 14'h0040,
        ST_RD0      = 14'h0080,
        ST_RD1      = 14'h0100,
        ST_RD2      = 14'h0200,
        ST_RD3      = 14'h0400,
        ST_ACC      = 14'h0800,
        ST_MUL      = 14'h1000,
        ST_OUT      = 14'h2000
    } t_state;

    typedef struct packed {
        logic       take;       // capture the input item
        logic       clr_step;   // write one entry of the clearing pass
        logic       wr_en;      // store the captured spin
        logic       div_mul;    // multiply divide operand by reciprocal
        logic       div_fix_z;  // finish first divide: z and x*S+y
        logic       div_fix_y;  // finish second divide: y and x
        logic       rd_en;      // issue a neighbor read pair
        logic [1:0] rd_sel;     // which pair
        logic       mul_en;     // multiply coupling by agreement sum
        logic       out_load;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;  // clearing pass at its last entry
        logic in_range;  // captured site lies inside the lattice
        logic out_free;  // result register can take a new result
    } t_status;

    // +1 when two spins agree, -1 when they differ
    function automatic logic signed [SUM_W-1:0] agree_term(input logic a, input logic b);
        agree_term = (a == b) ? 4'sd1 : -4'sd1;
    endfunction

endpackage

>>> hdl/ising3d_spin_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; used for the spin store.
`timescale 1ns / 1ps

module ising3d_spin_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> hdl/ising3d_datapath.sv
// Datapath: item capture, divide-by-side unit, neighbor addressing, spin RAM,
// agreement accumulator, coupling multiply and result register.
// Depends on ising3d_pkg and ising3d_spin_ram.
`timescale 1ns / 1ps

module ising3d_datapath
    import ising3d_pkg::*;
#(
    parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic [SITE_W-1:0]            i_site_index,
    input  logic                         i_spin_up,
    input  logic                         i_cfg_we,
    input  logic [COUPLING_W-1:0]        i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [ENERGY_W-1:0]   o_energy,
    output logic signed [SUM_W-1:0]      o_agreement_sum
);

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    localparam int ADDR_W     = $clog2(SITE_COUNT);
    localparam int COORD_W    = $clog2(LATTICE_SIDE);
    localparam int CMP_W      = ((ADDR_W > SITE_W) ? ADDR_W : SITE_W) + 1;
    localparam int PROD_W     = SITE_W + DIV_SHIFT;
    localparam int EPROD_W    = COUPLING_W + SUM_W;

    localparam logic [CMP_W-1:0]     SITE_LIMIT = CMP_W'(SITE_COUNT);
    localparam logic [ADDR_W-1:0]    LAST_SITE  = ADDR_W'(SITE_COUNT - 1);
    localparam logic [DIV_SHIFT-1:0] RECIP      = DIV_SHIFT'((64'd1 << DIV_SHIFT) / LATTICE_SIDE);
    localparam logic [SITE_W-1:0]    SIDE_OP    = SITE_W'(LATTICE_SIDE);
    localparam logic [COORD_W-1:0]   SIDE_MAX   = COORD_W'(LATTICE_SIDE - 1);
    localparam logic [ADDR_W-1:0]    ONE_A      = ADDR_W'(1);
    localparam logic [ADDR_W-1:0]    STEP_Y     = ADDR_W'(LATTICE_SIDE);
    localparam logic [ADDR_W-1:0]    STEP_X     = ADDR_W'(LATTICE_SIDE * LATTICE_SIDE);
    localparam logic [ADDR_W-1:0]    WRAP_Z     = ADDR_W'(LATTICE_SIDE - 1);
    localparam logic [ADDR_W-1:0]    WRAP_Y     = ADDR_W'(LATTICE_SIDE * (LATTICE_SIDE - 1));
    localparam logic [ADDR_W-1:0]    WRAP_X     =
        ADDR_W'(LATTICE_SIDE * LATTICE_SIDE * (LATTICE_SIDE - 1));

    // Captured item
    logic [ADDR_W-1:0]  r_site;
    logic               r_spin;
    logic               r_in_range;

    // Divide unit and coordinates
    logic [SITE_W-1:0]  r_div_op;
    logic [PROD_W-1:0]  r_div_prod;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [SITE_W-1:0]  q_est, q_fix, rem_raw, rem_fix;
    logic [2*SITE_W-1:0] q_mul;
    logic               rem_over;

    // Clearing pass and RAM
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               ram_we, ram_wdata, rd_a, rd_b;
    logic [ADDR_W-1:0]  ram_waddr, raddr_a, raddr_b;
    logic [ADDR_W-1:0]  addr_zm, addr_zp, addr_ym, addr_yp, addr_xm, addr_xp;

    // Accumulator and multiply
    logic               r_acc_en;
    logic [1:0]         r_acc_sel;
    logic               r_self;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [COUPLING_W-1:0] r_coupling;
    logic signed [EPROD_W-1:0]  r_eprod;
    logic signed [EPROD_W-1:0]  neg_eprod;

    logic r_out_valid;

    // Divide by the lattice side: estimate by reciprocal, then one correction
    assign q_est    = r_div_prod[DIV_SHIFT +: SITE_W];
    assign q_mul    = q_est * SIDE_OP;
    assign rem_raw  = r_div_op - q_mul[SITE_W-1:0];
    assign rem_over = (rem_raw >= SIDE_OP);
    assign q_fix    = rem_over ? (q_est + SITE_W'(1)) : q_est;
    assign rem_fix  = rem_over ? (rem_raw - SIDE_OP) : rem_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_site     <= ADDR_W'(i_site_index);
            r_spin     <= i_spin_up;
            r_in_range <= (CMP_W'(i_site_index) < SITE_LIMIT);
            r_div_op   <= i_site_index;
        end
        if (i_cmd.div_mul) begin
            r_div_prod <= PROD_W'(r_div_op) * PROD_W'(RECIP);
        end
        if (i_cmd.div_fix_z) begin
            r_z      <= rem_fix[COORD_W-1:0];
            r_div_op <= q_fix;
        end
        if (i_cmd.div_fix_y) begin
            r_y <= rem_fix[COORD_W-1:0];
            r_x <= q_fix[COORD_W-1:0];
        end
    end

    // Neighbor addresses with periodic wrap
    assign addr_zm = (r_z == '0)       ? r_site + WRAP_Z : r_site - ONE_A;
    assign addr_zp = (r_z == SIDE_MAX) ? r_site - WRAP_Z : r_site + ONE_A;
    assign addr_ym = (r_y == '0)       ? r_site + WRAP_Y : r_site - STEP_Y;
    assign addr_yp = (r_y == SIDE_MAX) ? r_site - WRAP_Y : r_site + STEP_Y;
    assign addr_xm = (r_x == '0)       ? r_site + WRAP_X : r_site - STEP_X;
    assign addr_xp = (r_x == SIDE_MAX) ? r_site - WRAP_X : r_site + STEP_X;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SELF_ZM: begin
                raddr_a = r_site;
                raddr_b = addr_zm;
            end
            RD_ZP_YM: begin
                raddr_a = addr_zp;
                raddr_b = addr_ym;
            end
            RD_YP_XM: begin
                raddr_a = addr_yp;
                raddr_b = addr_xm;
            end
            default: begin
                raddr_a = addr_xp;
                raddr_b = r_site;
            end
        endcase
    end

    assign ram_we    = i_cmd.clr_step | (i_cmd.wr_en & r_in_range);
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : r_site;
    assign ram_wdata = i_cmd.clr_step ? 1'b1 : r_spin;

    ising3d_spin_ram #(
        .WIDTH (1),
        .DEPTH (SITE_COUNT)
    ) u_spin_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Control registers: clearing counter, read pipeline tag, result valid, coupling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_acc_en    <= 1'b0;
            r_acc_sel   <= RD_SELF_ZM;
            r_out_valid <= 1'b0;
            r_coupling  <= COUPLING_RESET;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ONE_A;
            end
            r_acc_en  <= i_cmd.rd_en;
            r_acc_sel <= i_cmd.rd_sel;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_coupling <= $signed(i_cfg_data);
            end
        end
    end

    // Agreement accumulator, fed in the cycle after each read pair is issued
    always_ff @(posedge i_clk) begin
        if (r_acc_en) begin
            case (r_acc_sel)
                RD_SELF_ZM: begin
                    r_self <= rd_a;
                    r_sum  <= agree_term(rd_a, rd_b);
                end
                RD_ZP_YM, RD_YP_XM: begin
                    r_sum <= r_sum + agree_term(r_self, rd_a) + agree_term(r_self, rd_b);
                end
                default: begin
                    r_sum <= r_sum + agree_term(r_self, rd_a);
                end
            endcase
        end
        if (i_cmd.mul_en) begin
            r_eprod <= r_coupling * r_sum;
        end
        if (i_cmd.out_load) begin
            if (r_in_range) begin
                o_energy        <= neg_eprod[ENERGY_W-1:0];
                o_agreement_sum <= r_sum;
            end else begin
                o_energy        <= '0;
                o_agreement_sum <= '0;
            end
        end
    end

    assign neg_eprod = -r_eprod;

    assign o_out_valid       = r_out_valid;
    assign o_status.clr_last = (r_clr_addr == LAST_SITE);
    assign o_status.in_range = r_in_range;
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (~r_out_valid | i_out_ready))
        else $error("result loaded over an untaken result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_fix_y |=> (r_x <= SIDE_MAX && r_y <= SIDE_MAX && r_z <= SIDE_MAX))
        else $error("coordinate outside the lattice");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_en |-> (r_sum <= 4'sd6 && r_sum >= -4'sd6))
        else $error("agreement sum out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en & r_in_range) |-> (CMP_W'(r_site) < SITE_LIMIT && !i_cmd.clr_step))
        else $error("spin write outside the lattice or during clearing");

endmodule

>>> hdl/ising3d_ctrl.sv
// Controller: one-hot sequencer for clearing, spin writes and evaluations.
// Depends on ising3d_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps

module ising3d_ctrl
    import ising3d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_action,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = (i_action == ACTION_WRITE) ? ST_WRITE : ST_DIV_MUL1;
                end
            end
            ST_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DIV_MUL1: begin
                if (i_status.in_range) begin
                    o_cmd.div_mul = 1'b1;
                    n_state = ST_DIV_FIX1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV_FIX1: begin
                o_cmd.div_fix_z = 1'b1;
                n_state = ST_DIV_MUL2;
            end
            ST_DIV_MUL2: begin
                o_cmd.div_mul = 1'b1;
                n_state = ST_DIV_FIX2;
            end
            ST_DIV_FIX2: begin
                o_cmd.div_fix_y = 1'b1;
                n_state = ST_RD0;
            end
            ST_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SELF_ZM;
                n_state = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ZP_YM;
                n_state = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_YP_XM;
                n_state = ST_RD3;
            end
            ST_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_XP;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ising_3d_local_energy_unit.sv
// Evaluate: coordinate divide, neighbor pair reads, sum, coupling multiply, result load.
// Out-of-lattice evaluate: zero result, no reads. In-lattice spin write: stored. All end in idle.
// The evaluation time is set by the two-step divide-by-side unit and the spin RAM,
// which gives two reads a cycle for the seven spins of a site and its neighbors.
// Reset (i_rst_n low, synchronous): coupling back to 1.0, then a clearing pass over all
// LATTICE_SIDE^3 sites (4096 by default) sets every spin up; tready stays low meanwhile.
`timescale 1ns / 1ps

module ising_3d_local_energy_unit
    import ising3d_pkg::*;
#(
    parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] site_index, [12] spin_up, rest zero
    input  logic [0:0]             s_axis_tuser,   // [0] action: 0 write, 1 evaluate
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [18:0] energy, [22:19] agreement_sum, [23] 0
    // Coupling register write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [COUPLING_W-1:0]  i_cfg_data      // coupling J, signed Q8.8
);

    t_cmd    cmd;
    t_status status;

    logic signed [ENERGY_W-1:0] energy;
    logic signed [SUM_W-1:0]    agreement_sum;

    // Write the coupling register only while idle; not enforced, so always take the transfer
    assign o_cfg_ready = 1'b1;

    // Sequencer: owns the handshake on the input side and steps the datapath
    ising3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser[0]),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Datapath: spin store, neighbor addressing, accumulate, multiply, result register
    ising3d_datapath #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_site_index    (s_axis_tdata[SITE_W-1:0]),
        .i_spin_up       (s_axis_tdata[SITE_W]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_energy        (energy),
        .o_agreement_sum (agreement_sum)
    );

    // Pack the result: energy in the low bits, then the agreement sum, zero fill
    assign m_axis_tdata = {
        {(OUT_TDATA_W - ENERGY_W - SUM_W){1'b0}},
        agreement_sum,
        energy
    };

endmodule
